>>> rtl/knob_pkg.sv
// shared widths, codes and reset values for the knob and click event decoder
package knob_pkg;

    localparam int TICK_W  = 10;
    localparam int TURN_W  = 3;
    localparam int CLICK_W = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [TICK_W-1:0] DEBOUNCE_RESET     = 10'd50;
    localparam logic [TICK_W-1:0] DOUBLE_CLICK_RESET = 10'd250;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK = 1'd1;

    // turn codes
    localparam logic [TURN_W-1:0] TURN_NONE     = 3'd0;
    localparam logic [TURN_W-1:0] TURN_VOL_DOWN = 3'd1;
    localparam logic [TURN_W-1:0] TURN_VOL_UP   = 3'd2;
    localparam logic [TURN_W-1:0] TURN_PREV     = 3'd3;
    localparam logic [TURN_W-1:0] TURN_NEXT     = 3'd4;

    // click codes
    localparam logic [CLICK_W-1:0] CLICK_NONE = 2'd0;
    localparam logic [CLICK_W-1:0] CLICK_PLAY = 2'd1;
    localparam logic [CLICK_W-1:0] CLICK_MUTE = 2'd2;

endpackage

>>> rtl/knob_and_click_event_decoder_unit.sv
// knob and click event decoder: encoder direction, debounced button and double click
//
// usage
//   input channel (s_valid/s_ready): one request per millisecond tick carrying
//   the sampled encoder lines a and b, the active-low button level and the
//   host link flag
//   result channel (m_valid/m_ready): exactly one request per input request,
//   carrying turn_key and click_key (zero means no event)
//   configuration: cfg_wr_en with cfg_index selects debounce_ticks (0) or
//   double_click_ticks (1); write only while no request is in flight
// timing
//   an accepted request sits one cycle in the input register, the decode runs
//   in a single pass from there into the result register, so the result is
//   offered from the next edge and taken two edges after acceptance at best;
//   one request per cycle is sustained as both registers move together
// reset
//   aresetn low empties both registers and restores the idle line state
//   (a high, button released, no window open) and the default tick counts
// stall
//   with m_ready low the result holds, the input register fills, then s_ready
//   drops until the result is taken
module knob_and_click_event_decoder_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [knob_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [knob_pkg::TICK_W-1:0]     cfg_wdata,
    // sample requests
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_a_level,
    input  logic                            s_b_level,
    input  logic                            s_key_level,
    input  logic                            s_link_up,
    // event requests
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [knob_pkg::TURN_W-1:0]     m_turn_key,
    output logic [knob_pkg::CLICK_W-1:0]    m_click_key
);
    import knob_pkg::*;

    // configuration registers
    logic [TICK_W-1:0] debounce_ticks_reg;
    logic [TICK_W-1:0] double_click_ticks_reg;

    // input register
    logic in_valid_reg;
    logic a_reg, b_reg, key_reg, link_reg;

    // decoder state
    logic              prev_a_reg,          prev_a_next;
    logic              prev_key_reg,        prev_key_next;
    logic              confirming_reg,      confirming_next;
    logic [TICK_W-1:0] confirm_count_reg,   confirm_count_next;
    logic              awaiting_second_reg, awaiting_second_next;
    logic [TICK_W-1:0] press_timer_reg,     press_timer_next;

    // result register
    logic               out_valid_reg;
    logic [TURN_W-1:0]  turn_key_reg,  turn_key_next;
    logic [CLICK_W-1:0] click_key_reg, click_key_next;

    logic advance;
    logic hit;
    logic right;
    logic [TICK_W-1:0] count_inc;
    logic [TICK_W:0]   elapsed;

    // the input register moves into the result register when that one is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign m_valid     = out_valid_reg;
    assign m_turn_key  = turn_key_reg;
    assign m_click_key = click_key_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg     <= DEBOUNCE_RESET;
            double_click_ticks_reg <= DOUBLE_CLICK_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DEBOUNCE:     debounce_ticks_reg     <= cfg_wdata;
                REG_DOUBLE_CLICK: double_click_ticks_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // single-pass decode of the sample held in the input register
    always_comb begin
        prev_a_next          = a_reg;
        prev_key_next        = prev_key_reg;
        confirming_next      = confirming_reg;
        confirm_count_next   = confirm_count_reg;
        awaiting_second_next = awaiting_second_reg;
        press_timer_next     = press_timer_reg;
        turn_key_next        = TURN_NONE;
        click_key_next       = CLICK_NONE;
        hit                  = 1'b0;
        count_inc            = confirm_count_reg + 1'b1;
        elapsed              = {1'b0, press_timer_reg} + 1'b1;

        // direction: b unlike the previous a means a right turn
        right = (b_reg != prev_a_reg);
        if (a_reg != prev_a_reg) begin
            if (key_reg) begin
                turn_key_next = right ? TURN_VOL_UP : TURN_VOL_DOWN;
            end else begin
                turn_key_next = right ? TURN_NEXT : TURN_PREV;
            end
        end

        if (!link_reg) begin
            // link down: no events, click tracking frozen
            turn_key_next = TURN_NONE;
        end else begin
            // debounce
            if (!key_reg && prev_key_reg) begin
                confirm_count_next = '0;
                if (debounce_ticks_reg == '0) begin
                    confirming_next = 1'b0;
                    hit             = 1'b1;
                end else begin
                    confirming_next = 1'b1;
                end
            end else if (confirming_reg) begin
                if (key_reg) begin
                    confirming_next = 1'b0;
                end else begin
                    confirm_count_next = count_inc;
                    if (count_inc >= debounce_ticks_reg) begin
                        confirming_next = 1'b0;
                        hit             = 1'b1;
                    end
                end
            end

            // double-click window; expiry wins over a press on the same tick
            if (awaiting_second_reg) begin
                if (elapsed >= {1'b0, double_click_ticks_reg}) begin
                    click_key_next       = CLICK_MUTE;
                    awaiting_second_next = 1'b0;
                end else if (hit) begin
                    click_key_next       = CLICK_PLAY;
                    awaiting_second_next = 1'b0;
                    hit                  = 1'b0;
                end else begin
                    press_timer_next = elapsed[TICK_W-1:0];
                end
            end
            // a press not used as a second press opens a fresh window
            if (hit) begin
                awaiting_second_next = 1'b1;
                press_timer_next     = '0;
            end
            prev_key_next = key_reg;
        end
    end

    // control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            prev_a_reg          <= 1'b1;
            prev_key_reg        <= 1'b1;
            confirming_reg      <= 1'b0;
            confirm_count_reg   <= '0;
            awaiting_second_reg <= 1'b0;
            press_timer_reg     <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg       <= 1'b1;
                prev_a_reg          <= prev_a_next;
                prev_key_reg        <= prev_key_next;
                confirming_reg      <= confirming_next;
                confirm_count_reg   <= confirm_count_next;
                awaiting_second_reg <= awaiting_second_next;
                press_timer_reg     <= press_timer_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_reg    <= s_a_level;
            b_reg    <= s_b_level;
            key_reg  <= s_key_level;
            link_reg <= s_link_up;
        end
        if (advance) begin
            turn_key_reg  <= turn_key_next;
            click_key_reg <= click_key_next;
        end
    end

`ifndef NO_ASSERTIONS
    // with the link down no event leaves the block
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !link_reg |=> m_turn_key == TURN_NONE && m_click_key == CLICK_NONE)
        else $error("event reported while link down");

    // with the link down the click tracking holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !link_reg |=> $stable(awaiting_second_reg) && $stable(press_timer_reg)
            && $stable(prev_key_reg) && $stable(confirming_reg))
        else $error("click state moved while link down");

    // no turn without a change on line a
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (a_reg == prev_a_reg) |=> m_turn_key == TURN_NONE)
        else $error("turn reported without an edge on a");

    // a play/pause always closes the window
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && click_key_next == CLICK_PLAY |=> !awaiting_second_reg)
        else $error("window still open after double click");

    // a click event needs an open window
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !awaiting_second_reg |=> m_click_key == CLICK_NONE)
        else $error("click reported with no window open");
`endif

endmodule
